FILE: hdl/itp_pkg.sv
// package for the integer text parser
// types, character codes, register indexes and the digit decode function
package itp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 8;
  localparam int CH_BITS    = 8;
  localparam int ADDR_BITS  = 2;

  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(255);

  localparam logic [VALUE_BITS-1:0] VALUE_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VALUE_NONE = {VALUE_BITS{1'b1}};

  localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_X_LO  = 8'h78;
  localparam logic [CH_BITS-1:0] CH_X_UP  = 8'h58;
  localparam logic [CH_BITS-1:0] CH_0     = 8'h30;
  localparam logic [CH_BITS-1:0] CH_9     = 8'h39;
  localparam logic [CH_BITS-1:0] CH_A_LO  = 8'h61;
  localparam logic [CH_BITS-1:0] CH_F_LO  = 8'h66;
  localparam logic [CH_BITS-1:0] CH_A_UP  = 8'h41;
  localparam logic [CH_BITS-1:0] CH_F_UP  = 8'h46;

  localparam logic [ADDR_BITS-1:0] REG_START_DECIMAL  = 2'd0;
  localparam logic [ADDR_BITS-1:0] REG_SKIP_LEADING   = 2'd1;
  localparam logic [ADDR_BITS-1:0] REG_NONE_GIVES_MIN = 2'd2;

  typedef struct packed {
    logic start_decimal;
    logic skip_leading;
    logic none_gives_min;
  } cfg_t;

  typedef struct packed {
    logic                  active;
    logic                  trimming;
    logic                  hex_now;
    logic                  neg_mark;
    logic                  any_found;
    logic [VALUE_BITS-1:0] accum;
    logic [COUNT_BITS-1:0] char_count;
  } state_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] number;
    logic                         found;
    logic [COUNT_BITS-1:0]        consumed;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(logic [CH_BITS-1:0] c, logic hex);
    digit_t d;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d.ok  = 1'b1;
      d.val = c[3:0];
    end else if (hex && ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP))) begin
      d.ok  = 1'b1;
      d.val = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

FILE: hdl/itp_in_if.sv
// character channel of the integer text parser
// depends on itp_pkg
interface itp_in_if;
  logic                        valid;
  logic                        ready;
  logic [itp_pkg::CH_BITS-1:0] ch;
  logic                        first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

FILE: hdl/itp_out_if.sv
// result channel of the integer text parser
// depends on itp_pkg
interface itp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [itp_pkg::VALUE_BITS-1:0] number;
  logic                                  found;
  logic [itp_pkg::COUNT_BITS-1:0]        consumed;

  modport source (output valid, output number, output found, output consumed, input ready);
  modport sink   (input valid, input number, input found, input consumed, output ready);
endinterface

FILE: hdl/itp_step.sv
// next-state and result logic for one character word
// depends on itp_pkg
module itp_step (
  input  itp_pkg::cfg_t                 cfg,
  input  itp_pkg::state_t               cur,
  input  logic [itp_pkg::CH_BITS-1:0]   ch,
  input  logic                          first,
  output itp_pkg::state_t               nxt,
  output logic                          emit,
  output itp_pkg::result_t              res
);

  itp_pkg::state_t                  base;
  itp_pkg::digit_t                  dig;
  logic [itp_pkg::VALUE_BITS-1:0]   scaled;
  logic [itp_pkg::COUNT_BITS-1:0]   cnt_inc;
  logic                             is_minus;
  logic                             is_x;

  // restart on first word
  always_comb begin
    base = cur;
    if (first) begin
      base.active     = 1'b1;
      base.trimming   = cfg.skip_leading;
      base.hex_now    = ~cfg.start_decimal;
      base.neg_mark   = 1'b0;
      base.any_found  = 1'b0;
      base.accum      = '0;
      base.char_count = '0;
    end
  end

  assign dig      = itp_pkg::digit_of(ch, base.hex_now);
  assign is_minus = (ch == itp_pkg::CH_MINUS);
  assign is_x     = (ch == itp_pkg::CH_X_LO) || (ch == itp_pkg::CH_X_UP);
  assign cnt_inc  = (base.char_count < itp_pkg::MAX_COUNT) ? base.char_count + 1'b1
                                                          : base.char_count;
  assign scaled   = base.hex_now ? (base.accum << 4)
                                 : ((base.accum << 3) + (base.accum << 1));

  always_comb begin
    nxt  = base;
    emit = 1'b0;
    if (base.active) begin
      if (ch == itp_pkg::CH_NUL) begin
        emit       = 1'b1;
        nxt.active = 1'b0;
      end else if (base.trimming && !dig.ok && !is_minus) begin
        nxt.char_count = cnt_inc;
      end else begin
        nxt.trimming = 1'b0;
        if (dig.ok) begin
          nxt.accum      = scaled + itp_pkg::VALUE_BITS'(dig.val);
          nxt.any_found  = 1'b1;
          nxt.char_count = cnt_inc;
        end else if (base.accum != '0) begin
          emit       = 1'b1;
          nxt.active = 1'b0;
        end else if (is_x) begin
          nxt.hex_now    = 1'b1;
          nxt.any_found  = 1'b1;
          nxt.char_count = cnt_inc;
        end else if (is_minus) begin
          nxt.neg_mark   = 1'b1;
          nxt.any_found  = 1'b1;
          nxt.char_count = cnt_inc;
        end else begin
          emit       = 1'b1;
          nxt.active = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (base.any_found) begin
      res.number = base.neg_mark ? -$signed(base.accum) : $signed(base.accum);
    end else begin
      res.number = cfg.none_gives_min ? $signed(itp_pkg::VALUE_MIN)
                                      : $signed(itp_pkg::VALUE_NONE);
    end
    res.found    = base.any_found;
    res.consumed = base.char_count;
  end

endmodule

FILE: hdl/integer_text_parser_core.sv
// integer text parser: one character word in, one result word per parsed number
// the terminating word is held in the s1 register, then its result in the result register
// throughput: one character word per cycle; the input stalls only while a
// terminating word waits on a full result register
// reset: synchronous active-low rst_n clears parse state, valid flags and
// loads the configuration defaults
module integer_text_parser_core (
  input  logic                            clk,
  input  logic                            rst_n,
  itp_in_if.sink                          in_chan,
  itp_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [itp_pkg::ADDR_BITS-1:0]   cfg_addr,
  input  logic                            cfg_wdata
);

  itp_pkg::cfg_t                  cfg_r, cfg_nxt;
  itp_pkg::state_t                st_r, st_nxt;
  itp_pkg::result_t               out_res_r, step_res;
  logic                           out_valid_r, out_valid_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  logic [itp_pkg::CH_BITS-1:0]    s1_ch_r;
  logic                           s1_first_r;
  logic                           emit;
  logic                           step_go;
  logic                           in_acc;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        itp_pkg::REG_START_DECIMAL:  cfg_nxt.start_decimal  = cfg_wdata;
        itp_pkg::REG_SKIP_LEADING:   cfg_nxt.skip_leading   = cfg_wdata;
        itp_pkg::REG_NONE_GIVES_MIN: cfg_nxt.none_gives_min = cfg_wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  itp_step u_step (
    .cfg   (cfg_r),
    .cur   (st_r),
    .ch    (s1_ch_r),
    .first (s1_first_r),
    .nxt   (st_nxt),
    .emit  (emit),
    .res   (step_res)
  );

  assign step_go       = s1_valid_r && (!emit || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || step_go;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (step_go ? 1'b0 : s1_valid_r);

  always_comb begin
    if (step_go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{start_decimal: 1'b1, skip_leading: 1'b0, none_gives_min: 1'b0};
      st_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step_go) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r    <= in_chan.ch;
      s1_first_r <= in_chan.first;
    end
    if (step_go && emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.number   = out_res_r.number;
  assign out_chan.found    = out_res_r.found;
  assign out_chan.consumed = out_res_r.consumed;

endmodule
